### rtl/core/gnorm_pkg.sv
// Shared types, constants and table functions for the gated RMS norm block.
// No dependencies; imported by gnorm_rsqrt and gated_rms_norm_forward.
package gnorm_pkg;

    localparam int unsigned NEWTON_STEPS = 5;
    localparam logic [31:0] SEED_LO      = 32'd912680550;
    localparam logic [31:0] SEED_HI      = 32'd644245094;
    localparam logic [33:0] THREE_Q30    = 34'h0_C000_0000;
    localparam logic [33:0] TWO_Q30      = 34'h0_8000_0000;
    localparam logic [33:0] ONE_Q30      = 34'h0_4000_0000;
    localparam logic [33:0] FOUR_Q30     = 34'h1_0000_0000;
    localparam logic [5:0]  SHIFT_BASE   = 6'd45;

    // Reciprocal square root result and the final right shift it needs.
    typedef struct packed {
        logic [31:0] y;
        logic [5:0]  shift;
    } rsqrt_res_t;

    // Sigmoid of 0.0 .. 8.0 in steps of 0.5, unsigned Q0.16.
    function automatic logic [15:0] sig_tab(input logic [4:0] idx);
        logic [15:0] r;
        case (idx)
            5'd0:    r = 16'd32768;
            5'd1:    r = 16'd40793;
            5'd2:    r = 16'd47911;
            5'd3:    r = 16'd53581;
            5'd4:    r = 16'd57724;
            5'd5:    r = 16'd60565;
            5'd6:    r = 16'd62428;
            5'd7:    r = 16'd63615;
            5'd8:    r = 16'd64357;
            5'd9:    r = 16'd64816;
            5'd10:   r = 16'd65097;
            5'd11:   r = 16'd65269;
            5'd12:   r = 16'd65374;
            5'd13:   r = 16'd65438;
            5'd14:   r = 16'd65476;
            5'd15:   r = 16'd65500;
            default: r = 16'd65514;
        endcase
        return r;
    endfunction

    // Magnitude of a signed 16-bit value; the most negative value gives 32768.
    function automatic logic [15:0] mag16(input logic [15:0] v);
        logic [16:0] n;
        n = 17'd0 - {v[15], v};
        return v[15] ? n[15:0] : v;
    endfunction

endpackage

### rtl/core/gnorm_rsqrt.sv
// Mean square, epsilon add and reciprocal square root by Newton iteration.
// Depends on gnorm_pkg. One restoring divider and one shared 32x32 multiplier.
module gnorm_rsqrt #(
    parameter int NW = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [39:0]             sum,
    input  logic [NW-1:0]           n,
    input  logic [31:0]             epsilon,
    output logic                    done,
    output gnorm_pkg::rsqrt_res_t   res
);
    import gnorm_pkg::*;

    typedef enum logic [6:0] {
        RS_IDLE = 7'b0000001,
        RS_DIV  = 7'b0000010,
        RS_NORM = 7'b0000100,
        RS_SEED = 7'b0001000,
        RS_MT   = 7'b0010000,
        RS_MU   = 7'b0100000,
        RS_MY   = 7'b1000000
    } rs_state_t;

    rs_state_t       state_reg;
    logic [39:0]     dvd_reg;
    logic [NW:0]     rem_reg;
    logic [NW-1:0]   n_reg;
    logic [31:0]     eps_reg;
    logic [5:0]      bit_reg;
    logic [33:0]     m_reg;
    logic [5:0]      sh_reg;
    logic [31:0]     y_reg;
    logic [31:0]     t_reg;
    logic [31:0]     w_reg;
    logic [2:0]      step_reg;
    logic            done_reg;

    logic [NW:0]     rem_sh;
    logic            q_bit;
    logic [33:0]     v_sum;
    logic [31:0]     mul_a;
    logic [31:0]     mul_b;
    logic [63:0]     prod;
    logic [33:0]     u_val;

    always_comb
    begin
        rem_sh = {rem_reg[NW-1:0], dvd_reg[39]};
        q_bit  = (rem_sh >= {1'b0, n_reg});
        v_sum  = {1'b0, dvd_reg[32:0]} + {2'b00, eps_reg};
        mul_a  = y_reg;
        mul_b  = y_reg;
        case (state_reg)
            RS_MU:   begin mul_a = m_reg[31:0]; mul_b = t_reg; end
            RS_MY:   begin mul_a = y_reg;       mul_b = w_reg; end
            default: begin mul_a = y_reg;       mul_b = y_reg; end
        endcase
        prod  = {32'd0, mul_a} * {32'd0, mul_b};
        u_val = prod[63:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
            done_reg  <= 1'b0;
            bit_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= (state_reg == RS_MY) && (step_reg == 3'(NEWTON_STEPS - 1));
            unique case (state_reg)
                RS_IDLE:
                begin
                    if (start)
                    begin
                        dvd_reg   <= sum;
                        rem_reg   <= '0;
                        n_reg     <= n;
                        eps_reg   <= epsilon;
                        bit_reg   <= '0;
                        state_reg <= RS_DIV;
                    end
                end
                RS_DIV:
                begin
                    // One quotient bit per cycle, shifted in behind the dividend.
                    rem_reg <= q_bit ? rem_sh - {1'b0, n_reg} : rem_sh;
                    dvd_reg <= {dvd_reg[38:0], q_bit};
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'd39)
                    begin
                        state_reg <= RS_NORM;
                    end
                end
                RS_NORM:
                begin
                    // First pass loads the sum; zero is treated as the smallest step.
                    if (bit_reg == 6'd40)
                    begin
                        m_reg   <= (v_sum == 34'd0) ? 34'd1 : v_sum;
                        sh_reg  <= SHIFT_BASE;
                        bit_reg <= '0;
                    end
                    else if (m_reg >= FOUR_Q30)
                    begin
                        m_reg     <= m_reg >> 2;
                        sh_reg    <= SHIFT_BASE + 6'd1;
                        state_reg <= RS_SEED;
                    end
                    else if (m_reg < ONE_Q30)
                    begin
                        m_reg  <= m_reg << 2;
                        sh_reg <= sh_reg - 6'd1;
                    end
                    else
                    begin
                        state_reg <= RS_SEED;
                    end
                end
                RS_SEED:
                begin
                    y_reg     <= (m_reg >= TWO_Q30) ? SEED_HI : SEED_LO;
                    step_reg  <= '0;
                    state_reg <= RS_MT;
                end
                RS_MT:
                begin
                    t_reg     <= prod[61:30];
                    state_reg <= RS_MU;
                end
                RS_MU:
                begin
                    w_reg     <= (u_val >= THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - u_val);
                    state_reg <= RS_MY;
                end
                RS_MY:
                begin
                    y_reg    <= prod[62:31];
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'(NEWTON_STEPS - 1))
                    begin
                        state_reg <= RS_IDLE;
                    end
                    else
                    begin
                        state_reg <= RS_MT;
                    end
                end
                default: state_reg <= RS_IDLE;
            endcase
        end
    end

    assign done      = done_reg;
    assign res.y     = y_reg;
    assign res.shift = sh_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == RS_IDLE)
        else $error("rsqrt done outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RS_SEED) |-> (m_reg >= ONE_Q30) && (m_reg < FOUR_Q30))
        else $error("rsqrt operand not normalized");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RS_DIV) |-> rem_reg < {1'b0, n_reg})
        else $error("divider remainder out of range");

endmodule

### rtl/core/gated_rms_norm_forward.sv
// Gated RMS norm forward: buffers one head, then emits x*inv_rms*w*silu(g).
// Loading takes one element per cycle; after the last element the divider, the normalization
// and 5 Newton steps produce inv_rms, then the buffer is walked one element at a time, each
// result held while the output is not ready.
// Reset (rst_n, async low) clears control state and sets epsilon to 17;
// the element buffer holds no defined contents after reset.
module gated_rms_norm_forward #(
    parameter int MAX_HEAD_DIM = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // Element requests: tdata = x_value, gate_value, weight_value from bit 0 up.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // last_of_head
    // Result requests: tdata = out_value.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,   // last_out
    // Epsilon register write, unsigned Q8.24.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import gnorm_pkg::*;

    localparam int CW = $clog2(MAX_HEAD_DIM + 1);
    localparam int AW = (MAX_HEAD_DIM > 1) ? $clog2(MAX_HEAD_DIM) : 1;

    // One-hot sequencer: load the head, wait for inv_rms, then walk the buffer.
    typedef enum logic [7:0] {
        ST_LOAD = 8'b00000001,
        ST_NORM = 8'b00000010,
        ST_RD   = 8'b00000100,
        ST_E1   = 8'b00001000,
        ST_E2   = 8'b00010000,
        ST_E3   = 8'b00100000,
        ST_E4   = 8'b01000000,
        ST_E5   = 8'b10000000
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   k_reg;
    logic [39:0]     sum_reg;
    logic [31:0]     eps_reg;
    logic            start_reg;

    // Element buffer: x, gate and weight side by side, one synchronous memory.
    logic [47:0]     mem [MAX_HEAD_DIM];
    logic [47:0]     rd_reg;

    logic [16:0]     sig_reg;
    logic [15:0]     ga_reg;
    logic [31:0]     xw_reg;
    logic            neg_reg;
    logic [16:0]     silu_reg;
    logic [35:0]     a_reg;
    logic [49:0]     pp_hi_reg;
    logic [49:0]     pp_lo_reg;

    logic            m_valid_reg;
    logic [15:0]     m_data_reg;
    logic            m_last_reg;

    logic            accept;
    logic [CW-1:0]   count_inc;
    logic            close;
    logic signed [31:0] x_ext;
    logic [31:0]     x_sq;
    logic            rs_done;
    rsqrt_res_t      rs_res;

    logic [15:0]     xs, gs, ws;
    logic [15:0]     gm;
    logic [4:0]      sidx;
    logic [15:0]     t0, t1;
    logic [23:0]     slope;
    logic [16:0]     sig_pos;
    logic [33:0]     silu_full;
    logic [48:0]     a_full;
    logic [67:0]     prod;
    logic [67:0]     prod_rnd;
    logic [67:0]     p_val;
    logic [15:0]     sat_val;
    logic            out_ok;
    logic            is_last;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign count_inc     = count_reg + CW'(1);
    assign close         = s_axis_tlast || (count_inc == CW'(MAX_HEAD_DIM));
    // The square of a 16-bit value needs the full 32-bit product.
    assign x_ext         = 32'($signed(s_axis_tdata[15:0]));
    assign x_sq          = x_ext * x_ext;
    assign out_ok        = !m_valid_reg || m_axis_tready;
    assign is_last       = (k_reg == count_reg - CW'(1));

    // Table sigmoid with linear interpolation, then the output arithmetic.
    always_comb
    begin
        xs        = rd_reg[15:0];
        gs        = rd_reg[31:16];
        ws        = rd_reg[47:32];
        gm        = mag16(gs);
        sidx      = (gm[15:11] > 5'd16) ? 5'd16 : gm[15:11];
        t0        = sig_tab(sidx);
        t1        = sig_tab(sidx + 5'd1);
        slope     = 24'(t1 - t0) * {13'd0, gm[10:0]};
        sig_pos   = {1'b0, t0} + 17'(slope >> 11);
        silu_full = {1'b0, ga_reg} * {16'd0, sig_reg} + 34'd32768;
        a_full    = {17'd0, xw_reg} * {32'd0, silu_reg};
        prod      = ({18'd0, pp_hi_reg} << 18) + {18'd0, pp_lo_reg};
        prod_rnd  = prod + (68'd1 << (rs_res.shift - 6'd1));
        p_val     = prod_rnd >> rs_res.shift;
        if (neg_reg)
        begin
            sat_val = (p_val > 68'd32768) ? 16'h8000 : 16'(68'd0 - p_val);
        end
        else
        begin
            sat_val = (p_val > 68'd32767) ? 16'h7FFF : p_val[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[count_reg[AW-1:0]] <= s_axis_tdata;
        end
        rd_reg <= mem[k_reg[AW-1:0]];
    end

    gnorm_rsqrt #(.NW(CW)) u_rsqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .sum     (sum_reg),
        .n       (count_reg),
        .epsilon (eps_reg),
        .done    (rs_done),
        .res     (rs_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            k_reg       <= '0;
            sum_reg     <= '0;
            eps_reg     <= 32'd17;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            // The closing element of a head starts the inv_rms unit in the cycle after it is accepted.
            start_reg <= accept && close;
            if (cfg_valid)
            begin
                eps_reg <= cfg_data;
            end
            if (m_valid_reg && m_axis_tready && !((state_reg == ST_E5) && out_ok))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        count_reg <= count_inc;
                        sum_reg   <= sum_reg + {8'd0, x_sq};
                        if (close)
                        begin
                            state_reg <= ST_NORM;
                        end
                    end
                end
                ST_NORM:
                begin
                    if (rs_done)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_E1;
                end
                ST_E1:
                begin
                    sig_reg   <= gs[15] ? 17'd65536 - sig_pos : sig_pos;
                    ga_reg    <= gm;
                    xw_reg    <= {16'd0, mag16(xs)} * {16'd0, mag16(ws)};
                    neg_reg   <= xs[15] ^ ws[15] ^ gs[15];
                    state_reg <= ST_E2;
                end
                ST_E2:
                begin
                    silu_reg  <= silu_full[32:16];
                    state_reg <= ST_E3;
                end
                ST_E3:
                begin
                    a_reg     <= a_full[47:12];
                    state_reg <= ST_E4;
                end
                ST_E4:
                begin
                    // Split the wide product into two partial products.
                    pp_hi_reg <= {14'd0, a_reg[35:18]} * {18'd0, rs_res.y};
                    pp_lo_reg <= {14'd0, a_reg[17:0]} * {18'd0, rs_res.y};
                    state_reg <= ST_E5;
                end
                ST_E5:
                begin
                    if (out_ok)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= sat_val;
                        m_last_reg  <= is_last;
                        if (is_last)
                        begin
                            count_reg <= '0;
                            sum_reg   <= '0;
                            k_reg     <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + CW'(1);
                            state_reg <= ST_RD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> count_reg < CW'(MAX_HEAD_DIM))
        else $error("buffer full while accepting");
    assert property (@(posedge clk) disable iff (!rst_n)
        rs_done |-> state_reg == ST_NORM)
        else $error("inv_rms finished outside wait state");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_E5) && out_ok && is_last |=> state_reg == ST_LOAD && count_reg == '0)
        else $error("head not closed after last result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) && (state_reg != ST_NORM) |-> k_reg < count_reg)
        else $error("read index beyond head");

endmodule
